FILE: rtl/cpet_pkg.sv
// cpet_pkg: shared types and constants for the collision pair event tracker.
// No dependencies; used by every rtl file of the block.
`timescale 1ns / 1ps
package cpet_pkg;

    // event codes on the result word
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTER = 2'd1;
    localparam logic [1:0] EV_STAY  = 2'd2;
    localparam logic [1:0] EV_EXIT  = 2'd3;

    // operation codes on the input word
    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam int KEY_W = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the input word, reset the scan
        logic rd_en;     // read the slot at the scan index
        logic scan_inc;  // step to the next slot
        logic hit_set;   // key matched: record slot and touching bit
        logic finish;    // update table, emit the result word
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
        logic used_zero;
        logic last;
        logic key_match;
    } t_status;

endpackage

FILE: rtl/cpet_ctrl.sv
// cpet_ctrl: sequencer for lookup, insert and result of one word.
// Depends on cpet_pkg.
`timescale 1ns / 1ps
module cpet_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  cpet_pkg::t_status i_status,
    output cpet_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import cpet_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_status.is_clear || i_status.used_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CMP;
            end
            S_CMP: begin
                if (i_status.key_match) begin
                    o_cmd.hit_set = 1'b1;
                    n_state       = S_DONE;
                end else if (i_status.last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/cpet_dp.sv
// cpet_dp: pair table memory, scan counter, overlap test and result register.
// Depends on cpet_pkg.
`timescale 1ns / 1ps
module cpet_dp #(
    parameter int PAIR_SLOTS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cpet_pkg::t_cmd       i_cmd,
    output cpet_pkg::t_status    o_status,
    input  logic                 i_op,
    input  logic [31:0]          i_first_id,
    input  logic [31:0]          i_second_id,
    input  logic signed [23:0]   i_first_x,
    input  logic signed [23:0]   i_first_y,
    input  logic [22:0]          i_first_w,
    input  logic [22:0]          i_first_h,
    input  logic signed [23:0]   i_second_x,
    input  logic signed [23:0]   i_second_y,
    input  logic [22:0]          i_second_w,
    input  logic [22:0]          i_second_h,
    input  logic                 i_inactive,
    output logic                 o_valid,
    output logic [1:0]           o_event_res,
    output logic                 o_table_full
);
    import cpet_pkg::*;

    localparam int AW = $clog2(PAIR_SLOTS);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] SLOTS = CW'(PAIR_SLOTS);

    // latched word
    logic                r_op, r_inactive;
    logic [KEY_W-1:0]    r_key;
    logic signed [23:0]  r_ax, r_ay, r_bx, r_by;
    logic [22:0]         r_aw, r_ah, r_bw, r_bh;

    // scan and table state
    logic [CW-1:0]       r_idx, r_used;
    logic                r_found, r_was_t;
    logic [KEY_W:0]      r_q;
    logic [KEY_W:0]      r_mem [PAIR_SLOTS];

    // capture the word; key is ordered smaller id low
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_op;
            r_inactive <= i_inactive;
            r_key      <= (i_first_id < i_second_id) ? {i_second_id, i_first_id}
                                                     : {i_first_id, i_second_id};
            r_ax <= i_first_x;  r_ay <= i_first_y;
            r_aw <= i_first_w;  r_ah <= i_first_h;
            r_bx <= i_second_x; r_by <= i_second_y;
            r_bw <= i_second_w; r_bh <= i_second_h;
        end
    end

    // overlap test: 2*|d| < sa + sb on each axis
    function automatic logic axis_ov(logic signed [23:0] pa, logic signed [23:0] pb,
                                     logic [22:0] sa, logic [22:0] sb);
        logic signed [24:0] d;
        logic [24:0]        ad;
        logic [25:0]        twice;
        logic [23:0]        sum;
        d     = 25'(pa) - 25'(pb);
        ad    = d[24] ? 25'(-d) : 25'(d);
        twice = {ad, 1'b0};
        sum   = 24'(sa) + 24'(sb);
        return twice < 26'(sum);
    endfunction

    logic w_hit, w_insert, w_full;
    logic [AW-1:0] w_slot;
    logic w_was;
    logic [1:0] w_ev;

    always_comb begin
        w_hit    = !r_inactive && axis_ov(r_ax, r_bx, r_aw, r_bw)
                               && axis_ov(r_ay, r_by, r_ah, r_bh);
        w_insert = !r_found && (r_used != SLOTS);
        w_full   = !r_found && (r_used == SLOTS);
        w_slot   = r_found ? r_idx[AW-1:0] : r_used[AW-1:0];
        w_was    = r_found && r_was_t;
        if (w_hit) begin
            w_ev = w_was ? EV_STAY : EV_ENTER;
        end else begin
            w_ev = w_was ? EV_EXIT : EV_NONE;
        end
    end

    // scan counter, fill count and hit record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.finish;
            if (i_cmd.finish) begin
                if (r_op == OP_CLEAR) begin
                    r_used <= '0;
                end else if (w_insert) begin
                    r_used <= r_used + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.scan_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.hit_set) begin
            r_found <= 1'b1;
            r_was_t <= r_q[KEY_W];
        end
    end

    // pair table: {touching, key}
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_q <= r_mem[r_idx[AW-1:0]];
        end
        if (i_cmd.finish && (r_op == OP_CHECK) && !w_full) begin
            r_mem[w_slot] <= {w_hit, r_key};
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_event_res  <= (r_op == OP_CLEAR) ? EV_NONE : w_ev;
            o_table_full <= (r_op == OP_CHECK) && w_full;
        end
    end

    assign o_status.is_clear  = (r_op == OP_CLEAR);
    assign o_status.used_zero = (r_used == '0);
    assign o_status.last      = ((r_idx + 1'b1) == r_used);
    assign o_status.key_match = (r_q[KEY_W-1:0] == r_key);

endmodule

FILE: rtl/collision_pair_event_tracker_unit.sv
// Sequence: a clear, or a check on an empty table, goes through setup and done only;
// else a check scans the pair table memory linearly, a read state and a compare
// state per slot, until a key match or the last stored slot, then done.
// A new word is taken only while idle (busy low). Result strobe lasts one cycle.
// Reset: synchronous active low empties the table (fill count zero); no clearing pass.
// Depends on cpet_pkg, cpet_ctrl, cpet_dp.
`timescale 1ns / 1ps
module collision_pair_event_tracker_unit #(
    parameter int PAIR_SLOTS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_op,
    input  logic [31:0]         i_first_id,
    input  logic [31:0]         i_second_id,
    input  logic signed [23:0]  i_first_x,
    input  logic signed [23:0]  i_first_y,
    input  logic [22:0]         i_first_w,
    input  logic [22:0]         i_first_h,
    input  logic signed [23:0]  i_second_x,
    input  logic signed [23:0]  i_second_y,
    input  logic [22:0]         i_second_w,
    input  logic [22:0]         i_second_h,
    input  logic                i_inactive,
    output logic                o_valid,
    output logic [1:0]          o_event_res,
    output logic                o_table_full
);
    import cpet_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    cpet_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    cpet_dp #(.PAIR_SLOTS(PAIR_SLOTS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_op         (i_op),
        .i_first_id   (i_first_id),
        .i_second_id  (i_second_id),
        .i_first_x    (i_first_x),
        .i_first_y    (i_first_y),
        .i_first_w    (i_first_w),
        .i_first_h    (i_first_h),
        .i_second_x   (i_second_x),
        .i_second_y   (i_second_y),
        .i_second_w   (i_second_w),
        .i_second_h   (i_second_h),
        .i_inactive   (i_inactive),
        .o_valid      (o_valid),
        .o_event_res  (o_event_res),
        .o_table_full (o_table_full)
    );

endmodule

FILE: rtl/cpet_checker.sv
// cpet_checker: port-level assertions for the tracker, bound to the top level.
// Depends on cpet_pkg and collision_pair_event_tracker_unit.
`timescale 1ns / 1ps
module cpet_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [1:0] o_event_res,
    input logic       o_table_full
);
    import cpet_pkg::*;

    // an accepted word keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("no busy after accept");

    // a result word appears only once the block is free
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    // every finished word yields a result
    a_fell_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid) else $error("word finished without result");

    // an unstored pair had no touching history
    a_full_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (o_event_res == EV_NONE || o_event_res == EV_ENTER))
        else $error("stay or exit on unstored pair");

endmodule

bind collision_pair_event_tracker_unit cpet_checker u_cpet_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_event_res  (o_event_res),
    .o_table_full (o_table_full)
);
